>>> src/text_command_line_decoder_assert.svh
// Assertion macros for the command line decoder.
`ifndef TEXT_COMMAND_LINE_DECODER_ASSERT_SVH
`define TEXT_COMMAND_LINE_DECODER_ASSERT_SVH
`ifndef SYNTH
`define TCLD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tcld assertion failed");
`define TCLD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("tcld assertion failed");
`else
`define TCLD_ASSERT(label, prop)
`define TCLD_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> src/tcld_pkg.sv
package tcld_pkg;

    localparam int NUM_KW  = 6;
    localparam int KW_MAXC = 12;

    localparam logic [7:0] CHAR_NL   = 8'd10;
    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;

    localparam logic [2:0] CMD_TIME_RD = 3'd0;
    localparam logic [2:0] CMD_TIME_WR = 3'd1;
    localparam logic [2:0] CMD_GET_ALL = 3'd2;
    localparam logic [2:0] CMD_RUN_ON  = 3'd3;
    localparam logic [2:0] CMD_RUN_OFF = 3'd4;
    localparam logic [2:0] CMD_INTV_WR = 3'd5;

    // keyword text, right-justified, indexed by command id
    localparam logic [KW_MAXC*8-1:0] KW_TEXT [NUM_KW] = '{
        {"GET_", "TIME"}, {"SET_", "TIME"}, {"GET_ALL", "_MEAS"},
        {"WORK_MOD", "_ON"}, {"WORK_MOD", "_OFF"}, {"CHANGE", "_INT"}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd8, 4'd8, 4'd12, 4'd11, 4'd12, 4'd10};

    typedef enum logic [1:0] {
        PH_MATCH  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_NOKEY  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       is_nl;
        logic       is_digit;
        logic [3:0] digit;
    } t_item;

    // character of keyword k at position pos (left to right), zero past its end
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
        logic [KW_MAXC*8-1:0] w;
        logic [3:0]           l;
        logic [3:0]           sh;
        w  = KW_TEXT[k];
        l  = KW_LEN[k];
        sh = l - pos - 4'd1;
        kw_char = (pos < l) ? w[{sh, 3'b000} +: 8] : 8'h00;
    endfunction

endpackage

>>> src/text_command_line_decoder.sv
// Path: a newline accepted at the input is written into the queue; the back end
// pops it and registers the result, which can then be taken.
// Throughput: one byte per cycle, set by the back end's match and
// accumulate step, fed from a two-item queue. A newline waits while the previous
// result is not yet taken. Reset (synchronous, active low): line state cleared,
// run flag 0, interval 1, queue and result register empty.
`include "text_command_line_decoder_assert.svh"

module text_command_line_decoder #(
    parameter int ARG_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_line_ok,
    output logic [2:0]  o_command_id,
    output logic [31:0] o_argument,
    output logic        o_run_enabled,
    output logic [31:0] o_interval,
    output logic        o_time_request,
    output logic        o_dump_request
);

    tcld_pkg::t_item w_front_item;
    tcld_pkg::t_item w_q_item;
    logic            w_push;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_pop;

    tcld_front u_front (
        .i_valid  (i_rx_valid),
        .i_byte   (i_rx_byte),
        .i_q_full (w_q_full),
        .o_ready  (o_rx_ready),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    tcld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    tcld_back #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_item       (w_q_item),
        .o_pop          (w_pop),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_line_ok      (o_line_ok),
        .o_command_id   (o_command_id),
        .o_argument     (o_argument),
        .o_run_enabled  (o_run_enabled),
        .o_interval     (o_interval),
        .o_time_request (o_time_request),
        .o_dump_request (o_dump_request)
    );

    `TCLD_ASSERT(a_no_pop_when_empty, !w_q_valid |-> !w_pop)
    `TCLD_ASSERT(a_treq, o_res_valid && o_time_request |-> o_command_id == tcld_pkg::CMD_TIME_RD)
    `TCLD_ASSERT(a_nokey, o_res_valid && !o_line_ok |-> {o_command_id, o_argument} == '0)
    `TCLD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_res_valid && !w_q_valid)

endmodule

>>> src/tcld_front.sv
module tcld_front (
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output tcld_pkg::t_item    o_item
);

    logic [7:0] w_diff;

    assign w_diff  = i_byte - tcld_pkg::CHAR_ZERO;
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item.rx_byte  = i_byte;
        o_item.is_nl    = (i_byte == tcld_pkg::CHAR_NL);
        o_item.is_digit = (i_byte >= tcld_pkg::CHAR_ZERO) && (i_byte <= tcld_pkg::CHAR_NINE);
        o_item.digit    = w_diff[3:0];
    end

endmodule

>>> src/tcld_fifo.sv
module tcld_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcld_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tcld_pkg::t_item o_item
);

    localparam int DEPTH = 2;

    tcld_pkg::t_item r_mem [DEPTH];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

>>> src/tcld_back.sv
module tcld_back #(
    parameter int ARG_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tcld_pkg::t_item i_q_item,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic            o_line_ok,
    output logic [2:0]      o_command_id,
    output logic [31:0]     o_argument,
    output logic            o_run_enabled,
    output logic [31:0]     o_interval,
    output logic            o_time_request,
    output logic            o_dump_request
);

    tcld_pkg::t_phase       r_phase, n_phase;
    logic [5:0]             r_mask, n_mask;
    logic [3:0]             r_pos, n_pos;
    logic [2:0]             r_cmd, n_cmd;
    logic [ARG_WIDTH-1:0]   r_acc, n_acc;
    logic                   r_run, n_run;
    logic [31:0]            r_intv, n_intv;
    logic                   r_out_valid;

    logic                   w_found;
    logic [2:0]             w_fidx;
    logic [ARG_WIDTH-1:0]   w_acc_next;
    logic                   w_ok;
    logic [2:0]             w_id;
    logic [31:0]            w_arg;
    logic                   w_treq;
    logic                   w_dreq;
    logic                   w_line_end;

    assign o_pop      = i_q_valid && (!i_q_item.is_nl || !r_out_valid || i_res_ready);
    assign w_line_end = o_pop && i_q_item.is_nl;
    assign o_res_valid = r_out_valid;
    assign w_acc_next = {r_acc[ARG_WIDTH-4:0], 3'b000} + {r_acc[ARG_WIDTH-2:0], 1'b0}
                      + ARG_WIDTH'(i_q_item.digit);

    // lowest live keyword that ends at the current position
    always_comb begin
        w_found = 1'b0;
        w_fidx  = 3'd0;
        for (int k = tcld_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (r_mask[k] && (tcld_pkg::KW_LEN[k] == r_pos)) begin
                w_found = 1'b1;
                w_fidx  = 3'(k);
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_mask  = r_mask;
        n_pos   = r_pos;
        n_cmd   = r_cmd;
        n_acc   = r_acc;
        n_run   = r_run;
        n_intv  = r_intv;
        w_ok    = 1'b0;
        w_id    = 3'd0;
        w_arg   = 32'd0;
        w_treq  = 1'b0;
        w_dreq  = 1'b0;
        if (w_line_end) begin
            w_ok = (r_phase == tcld_pkg::PH_DIGITS) || (r_phase == tcld_pkg::PH_DONE)
                || ((r_phase == tcld_pkg::PH_MATCH) && w_found);
            if (w_ok) begin
                w_id  = (r_phase == tcld_pkg::PH_MATCH) ? w_fidx : r_cmd;
                w_arg = 32'(r_acc);
                case (w_id)
                    tcld_pkg::CMD_TIME_RD: w_treq = 1'b1;
                    tcld_pkg::CMD_GET_ALL: w_dreq = 1'b1;
                    tcld_pkg::CMD_RUN_ON:  n_run  = 1'b1;
                    tcld_pkg::CMD_RUN_OFF: n_run  = 1'b0;
                    tcld_pkg::CMD_INTV_WR: n_intv = w_arg;
                    default: ;
                endcase
            end
            n_phase = tcld_pkg::PH_MATCH;
            n_mask  = '1;
            n_pos   = 4'd0;
            n_cmd   = 3'd0;
            n_acc   = '0;
        end else if (o_pop) begin
            case (r_phase)
                tcld_pkg::PH_MATCH: begin
                    if (w_found) begin
                        n_cmd = w_fidx;
                        if (i_q_item.is_digit) begin
                            n_phase = tcld_pkg::PH_DIGITS;
                            n_acc   = w_acc_next;
                        end else begin
                            n_phase = tcld_pkg::PH_DONE;
                        end
                    end else begin
                        for (int k = 0; k < tcld_pkg::NUM_KW; k++) begin
                            if (r_mask[k] && ((r_pos >= tcld_pkg::KW_LEN[k])
                                || (tcld_pkg::kw_char(k, r_pos) != i_q_item.rx_byte))) begin
                                n_mask[k] = 1'b0;
                            end
                        end
                        n_pos = r_pos + 4'd1;
                        if (n_mask == 6'd0) begin
                            n_phase = tcld_pkg::PH_NOKEY;
                        end
                    end
                end
                tcld_pkg::PH_DIGITS: begin
                    if (i_q_item.is_digit) begin
                        n_acc = w_acc_next;
                    end else begin
                        n_phase = tcld_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tcld_pkg::PH_MATCH;
            r_mask      <= '1;
            r_pos       <= 4'd0;
            r_cmd       <= 3'd0;
            r_acc       <= '0;
            r_run       <= 1'b0;
            r_intv      <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_mask  <= n_mask;
            r_pos   <= n_pos;
            r_cmd   <= n_cmd;
            r_acc   <= n_acc;
            r_run   <= n_run;
            r_intv  <= n_intv;
            if (w_line_end) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_line_end) begin
            o_line_ok      <= w_ok;
            o_command_id   <= w_id;
            o_argument     <= w_arg;
            o_run_enabled  <= n_run;
            o_interval     <= n_intv;
            o_time_request <= w_treq;
            o_dump_request <= w_dreq;
        end
    end

endmodule
